### hdl/aoi_pkg.sv
// ----------------------------------------------------------------------------
// aoi_pkg
// Types, constants and codes shared by the area-of-interest table modules.
// ----------------------------------------------------------------------------
package aoi_pkg;

  localparam int ENTRIES     = 32;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int ADDR_W      = $clog2(ENTRIES);
  localparam int N_W         = $clog2(MAX_RESULTS + 1);
  localparam int BS_W        = 15;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_UPDATE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_MATCH  = 2'd1,
    KIND_ABSENT = 2'd2,
    KIND_FULL   = 2'd3
  } kind_t;

  typedef struct packed {
    op_t                op;
    logic        [15:0] entity_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] match_id;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        [15:0] id;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOC_RD,
    ST_LOC_CHK,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_INS_RD,
    ST_INS_CHK,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_FND_RD,
    ST_FND_CHK,
    ST_FND_END,
    ST_RESP_DONE,
    ST_RESP_ABSENT,
    ST_RESP_FULL
  } state_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_NEXT,
    RD_PREV
  } rd_sel_t;

  typedef struct packed {
    logic    take;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_end;
    logic    pos_idx;
    logic    pos_end;
    logic    center;
    logic    rd;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    wr_new;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    pend_load;
    logic    push_pend;
    logic    push_last;
    logic    push_resp;
    kind_t   resp_kind;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic idx_ge_cnt;
    logic idx1_ge_cnt;
    logic idx_eq_pos;
    logic id_match;
    logic x_gt_new;
    logic x_gt_maxx;
    logic in_win;
    logic n_max;
    logic pend_vld;
    logic out_free;
  } stat_t;

endpackage

### hdl/aoi_ctrl.sv
// ----------------------------------------------------------------------------
// aoi_ctrl
// Sequencer for the table operations: locate, delete, insert and find scans.
// ----------------------------------------------------------------------------
module aoi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  aoi_pkg::op_t   in_op,
  input  aoi_pkg::stat_t stat,
  output logic           in_ready,
  output aoi_pkg::cmd_t  cmd
);

  aoi_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aoi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aoi_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_op == aoi_pkg::OP_ADD) begin
            state_nxt = stat.full ? aoi_pkg::ST_RESP_FULL : aoi_pkg::ST_INS_RD;
          end else begin
            state_nxt = aoi_pkg::ST_LOC_RD;
          end
        end
      end
      aoi_pkg::ST_LOC_RD: begin
        if (stat.idx_ge_cnt) begin
          if (stat.op == aoi_pkg::OP_UPDATE) begin
            state_nxt = stat.full ? aoi_pkg::ST_RESP_FULL : aoi_pkg::ST_INS_RD;
          end else begin
            state_nxt = aoi_pkg::ST_RESP_ABSENT;
          end
        end else begin
          state_nxt = aoi_pkg::ST_LOC_CHK;
        end
      end
      aoi_pkg::ST_LOC_CHK: begin
        if (stat.id_match) begin
          state_nxt = (stat.op == aoi_pkg::OP_FIND) ? aoi_pkg::ST_FND_RD
                                                    : aoi_pkg::ST_DEL_RD;
        end else begin
          state_nxt = aoi_pkg::ST_LOC_RD;
        end
      end
      aoi_pkg::ST_DEL_RD: begin
        if (stat.idx1_ge_cnt) begin
          state_nxt = (stat.op == aoi_pkg::OP_UPDATE) ? aoi_pkg::ST_INS_RD
                                                      : aoi_pkg::ST_RESP_DONE;
        end else begin
          state_nxt = aoi_pkg::ST_DEL_WR;
        end
      end
      aoi_pkg::ST_DEL_WR:  state_nxt = aoi_pkg::ST_DEL_RD;
      aoi_pkg::ST_INS_RD: begin
        state_nxt = stat.idx_ge_cnt ? aoi_pkg::ST_SHF_RD : aoi_pkg::ST_INS_CHK;
      end
      aoi_pkg::ST_INS_CHK: begin
        state_nxt = stat.x_gt_new ? aoi_pkg::ST_SHF_RD : aoi_pkg::ST_INS_RD;
      end
      aoi_pkg::ST_SHF_RD: begin
        state_nxt = stat.idx_eq_pos ? aoi_pkg::ST_RESP_DONE : aoi_pkg::ST_SHF_WR;
      end
      aoi_pkg::ST_SHF_WR:  state_nxt = aoi_pkg::ST_SHF_RD;
      aoi_pkg::ST_FND_RD: begin
        state_nxt = (stat.idx_ge_cnt || stat.n_max) ? aoi_pkg::ST_FND_END
                                                     : aoi_pkg::ST_FND_CHK;
      end
      aoi_pkg::ST_FND_CHK: begin
        if (stat.x_gt_maxx) begin
          state_nxt = aoi_pkg::ST_FND_END;
        end else if (!stat.in_win || !stat.pend_vld || stat.out_free) begin
          state_nxt = aoi_pkg::ST_FND_RD;
        end
      end
      aoi_pkg::ST_FND_END,
      aoi_pkg::ST_RESP_DONE,
      aoi_pkg::ST_RESP_ABSENT,
      aoi_pkg::ST_RESP_FULL: begin
        if (stat.out_free) state_nxt = aoi_pkg::ST_IDLE;
      end
      default: state_nxt = aoi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.rd_sel    = aoi_pkg::RD_IDX;
    cmd.resp_kind = aoi_pkg::KIND_DONE;
    in_ready  = 1'b0;
    unique case (state_r)
      aoi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      aoi_pkg::ST_LOC_RD: begin
        if (stat.idx_ge_cnt) begin
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      aoi_pkg::ST_LOC_CHK: begin
        if (stat.id_match) begin
          cmd.pos_idx = 1'b1;
          cmd.center  = 1'b1;
          cmd.idx_clr = (stat.op == aoi_pkg::OP_FIND);
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      aoi_pkg::ST_DEL_RD: begin
        if (stat.idx1_ge_cnt) begin
          cmd.cnt_dec = 1'b1;
          cmd.idx_clr = 1'b1;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_sel = aoi_pkg::RD_NEXT;
        end
      end
      aoi_pkg::ST_DEL_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      aoi_pkg::ST_INS_RD: begin
        if (stat.idx_ge_cnt) begin
          cmd.pos_end = 1'b1;
          cmd.idx_end = 1'b1;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      aoi_pkg::ST_INS_CHK: begin
        if (stat.x_gt_new) begin
          cmd.pos_idx = 1'b1;
          cmd.idx_end = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      aoi_pkg::ST_SHF_RD: begin
        if (stat.idx_eq_pos) begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_sel = aoi_pkg::RD_PREV;
        end
      end
      aoi_pkg::ST_SHF_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
      end
      aoi_pkg::ST_FND_RD: begin
        cmd.rd = !(stat.idx_ge_cnt || stat.n_max);
      end
      aoi_pkg::ST_FND_CHK: begin
        if (!stat.x_gt_maxx) begin
          if (!stat.in_win) begin
            cmd.idx_inc = 1'b1;
          end else if (!stat.pend_vld) begin
            cmd.pend_load = 1'b1;
            cmd.idx_inc   = 1'b1;
          end else if (stat.out_free) begin
            cmd.push_pend = 1'b1;
            cmd.pend_load = 1'b1;
            cmd.idx_inc   = 1'b1;
          end
        end
      end
      aoi_pkg::ST_FND_END: begin
        cmd.push_pend = stat.out_free;
        cmd.push_last = 1'b1;
      end
      aoi_pkg::ST_RESP_DONE: begin
        cmd.push_resp = stat.out_free;
        cmd.resp_kind = aoi_pkg::KIND_DONE;
      end
      aoi_pkg::ST_RESP_ABSENT: begin
        cmd.push_resp = stat.out_free;
        cmd.resp_kind = aoi_pkg::KIND_ABSENT;
      end
      aoi_pkg::ST_RESP_FULL: begin
        cmd.push_resp = stat.out_free;
        cmd.resp_kind = aoi_pkg::KIND_FULL;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### hdl/aoi_dp.sv
// ----------------------------------------------------------------------------
// aoi_dp
// Entry memory, scan index, window compare and the result register.
// ----------------------------------------------------------------------------
module aoi_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  aoi_pkg::in_item_t          in_data,
  input  logic [aoi_pkg::BS_W-1:0]   block_size,
  input  aoi_pkg::cmd_t              cmd,
  input  logic                       out_ready,
  output aoi_pkg::stat_t             stat,
  output logic                       out_valid,
  output aoi_pkg::out_item_t         out_data
);

  aoi_pkg::entry_t                 mem [aoi_pkg::ENTRIES];
  aoi_pkg::entry_t                 rdata_r;
  aoi_pkg::in_item_t               req_r;
  logic [aoi_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [aoi_pkg::CNT_W-1:0]       idx_r, idx_nxt;
  logic [aoi_pkg::CNT_W-1:0]       pos_r;
  logic [aoi_pkg::N_W-1:0]         n_r;
  logic signed [15:0]              cx_r, cy_r;
  logic [15:0]                     pend_id_r;
  logic                            pend_vld_r;
  logic                            out_valid_r;
  aoi_pkg::out_item_t              out_data_r;

  logic [aoi_pkg::CNT_W-1:0]       idx_p1, idx_m1, rd_idx;
  logic [aoi_pkg::ADDR_W-1:0]      raddr, waddr;
  aoi_pkg::entry_t                 wdata;
  logic                            wr_en;
  logic signed [17:0]              dx, dy, bs_s;
  logic                            out_free;

  assign idx_p1 = idx_r + 1'b1;
  assign idx_m1 = idx_r - 1'b1;

  always_comb begin
    case (cmd.rd_sel)
      aoi_pkg::RD_NEXT: rd_idx = idx_p1;
      aoi_pkg::RD_PREV: rd_idx = idx_m1;
      default:          rd_idx = idx_r;
    endcase
  end

  assign raddr = rd_idx[aoi_pkg::ADDR_W-1:0];
  assign waddr = cmd.wr_new ? pos_r[aoi_pkg::ADDR_W-1:0] : idx_r[aoi_pkg::ADDR_W-1:0];
  assign wr_en = cmd.wr_shift | cmd.wr_new;
  assign wdata = cmd.wr_new ? aoi_pkg::entry_t'{req_r.entity_id, req_r.pos_x, req_r.pos_y}
                            : rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rdata_r <= mem[raddr];
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.take || cmd.idx_clr) idx_nxt = '0;
    else if (cmd.idx_end)        idx_nxt = cnt_r;
    else if (cmd.idx_inc)        idx_nxt = idx_p1;
    else if (cmd.idx_dec)        idx_nxt = idx_m1;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc)      cnt_nxt = cnt_r + 1'b1;
    else if (cmd.cnt_dec) cnt_nxt = cnt_r - 1'b1;
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      n_r         <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      if (cmd.take)           n_r <= '0;
      else if (cmd.pend_load) n_r <= n_r + 1'b1;
      if (cmd.take)           pend_vld_r <= 1'b0;
      else if (cmd.pend_load) pend_vld_r <= 1'b1;
      if (cmd.push_pend || cmd.push_resp) out_valid_r <= 1'b1;
      else if (out_ready)                 out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take)      req_r <= in_data;
    if (cmd.pos_idx)   pos_r <= idx_r;
    else if (cmd.pos_end) pos_r <= cnt_r;
    if (cmd.center) begin
      cx_r <= rdata_r.x;
      cy_r <= rdata_r.y;
    end
    if (cmd.pend_load) pend_id_r <= rdata_r.id;
    if (cmd.push_pend) begin
      out_data_r <= aoi_pkg::out_item_t'{aoi_pkg::KIND_MATCH, pend_id_r, cmd.push_last};
    end else if (cmd.push_resp) begin
      out_data_r <= aoi_pkg::out_item_t'{cmd.resp_kind, 16'd0, 1'b1};
    end
  end

  // Offsets from the center in 18 bits never wrap.
  assign dx   = 18'(rdata_r.x) - 18'(cx_r);
  assign dy   = 18'(rdata_r.y) - 18'(cy_r);
  assign bs_s = signed'({3'b000, block_size});

  always_comb begin
    stat.op          = req_r.op;
    stat.full        = (cnt_r == aoi_pkg::CNT_W'(aoi_pkg::ENTRIES));
    stat.idx_ge_cnt  = (idx_r >= cnt_r);
    stat.idx1_ge_cnt = (idx_p1 >= cnt_r);
    stat.idx_eq_pos  = (idx_r == pos_r);
    stat.id_match    = (rdata_r.id == req_r.entity_id);
    stat.x_gt_new    = (rdata_r.x > req_r.pos_x);
    stat.x_gt_maxx   = (dx > bs_s);
    stat.in_win      = (dx >= -bs_s) && (dy >= -bs_s) && (dy <= bs_s);
    stat.n_max       = (n_r == aoi_pkg::N_W'(aoi_pkg::MAX_RESULTS));
    stat.pend_vld    = pend_vld_r;
    stat.out_free    = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/area_of_interest_table.sv
// ----------------------------------------------------------------------------
// area_of_interest_table
// Table of entities sorted by x with add, update, remove and window search.
// ----------------------------------------------------------------------------
//
//   channel   handshake                    payload
//   in        in_valid / in_ready          in_data  (op, entity_id, pos_x, pos_y)
//   out       out_valid / out_ready        out_data (kind, match_id, last)
//   cfg       psel penable pwrite pready   paddr, pwdata, prdata (block_size)
//
// Requests: one request at a time. Every scan or shift step over the entry
// memory is a registered read, then a compare or a write back.
// Reset: the fill count clears, so no clearing pass runs; block_size is 0.
// Stalls: a full result register holds the find scan at the next match and
// holds the closing result; a new request is taken while a result waits.
//
module area_of_interest_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  aoi_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output aoi_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [aoi_pkg::BS_W-1:0] block_size_r;
  aoi_pkg::cmd_t            cmd;
  aoi_pkg::stat_t           stat;

  // Register block: block_size lies at byte address 0, word index in paddr[2].
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      block_size_r <= pwdata[aoi_pkg::BS_W-1:0];
    end
  end

  // Read back the register; other addresses read zero.
  assign prdata = (paddr == 3'd0) ? {{(32 - aoi_pkg::BS_W){1'b0}}, block_size_r} : 32'd0;

  // Sequencer: walks the table and issues memory and result commands.
  aoi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath: entry memory, index and count, window test, result register.
  aoi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .block_size (block_size_r),
    .cmd        (cmd),
    .out_ready  (out_ready),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

### hdl/aoi_chk.sv
// ----------------------------------------------------------------------------
// aoi_chk
// Port-level checks on the area-of-interest table, bound to the top level.
// ----------------------------------------------------------------------------
module aoi_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input aoi_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != aoi_pkg::KIND_MATCH |-> out_data.last)
    else $error("status result without last");

  a_status_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != aoi_pkg::KIND_MATCH |-> out_data.match_id == 16'd0)
    else $error("status result with nonzero id");

endmodule

bind area_of_interest_table aoi_chk u_aoi_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
